// File: hw/rtl/msp_pkg.sv
// msp_pkg: shared types, constants and register indexes for mask_row_to_spans.
// No dependencies; imported by every module of the block.
`default_nettype none

package msp_pkg;

  localparam int MAX_ROW_BYTES_DEF = 512;
  localparam int COORD_BITS_DEF    = 16;

  // spans one mask byte can close and deliver
  localparam int MAX_SPANS = 4;
  localparam int SPAN_CNT_W = 3;
  localparam int WIDTH_W   = 13;
  localparam int OUT_DATA_W = 48;
  localparam int IN_DATA_W  = 24;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] EDGE_MASK_RST = 8'hFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_EDGE_MASK_LEFT  = 2'd0,
    REG_EDGE_MASK_RIGHT = 2'd1,
    REG_ROW_START_X     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]         mask_byte;
    logic signed [15:0] row_y;
    logic               row_first;
    logic               row_last;
  } byte_item_t;

  typedef struct packed {
    logic signed [15:0]   x;
    logic [WIDTH_W-1:0]   width;
  } span_t;

  typedef struct packed {
    logic [SPAN_CNT_W-1:0]       cnt;
    logic signed [15:0]          y;
    span_t [MAX_SPANS-1:0]       spans;
  } span_set_t;

endpackage

`default_nettype wire

// File: hw/rtl/mask_row_to_spans.sv
// mask_row_to_spans: one mask byte per item becomes up to four spans (x, y, width).
// Takes one item per cycle when each byte yields at most one span and m_tready stays
// high; a byte that yields more spans holds back the next item while the result buffer
// drains one span per cycle as m_tready allows. Spans pass the input register, then the
// result buffer. Depends on msp_pkg, msp_in_stage, msp_span_scan, msp_span_buf.
`default_nettype none

module mask_row_to_spans import msp_pkg::*; #(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // mask_byte[7:0], row_y[23:8]
  input  wire logic                  s_tuser,  // row_first
  input  wire logic                  s_tlast,  // row_last
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,  // span_x[15:0], span_y[31:16],
                                               // span_width[44:32], zero[47:45]
  output logic                       m_tlast   // span_final
);

  logic [7:0]         edge_mask_left;
  logic [7:0]         edge_mask_right;
  logic signed [15:0] row_start_x;

  byte_item_t         s_item;
  byte_item_t         item;
  logic               item_valid;
  logic               can_load;
  logic               adv;
  span_set_t          set;
  span_t              head;
  logic signed [15:0] head_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_mask_left  <= EDGE_MASK_RST;
      edge_mask_right <= EDGE_MASK_RST;
      row_start_x     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_EDGE_MASK_LEFT:  edge_mask_left  <= cfg_wdata[7:0];
        REG_EDGE_MASK_RIGHT: edge_mask_right <= cfg_wdata[7:0];
        REG_ROW_START_X:     row_start_x     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s_item.mask_byte = s_tdata[7:0];
  assign s_item.row_y     = s_tdata[23:8];
  assign s_item.row_first = s_tuser;
  assign s_item.row_last  = s_tlast;

  assign adv = item_valid && can_load;

  msp_in_stage u_in (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_item          (s_item),
    .edge_mask_left  (edge_mask_left),
    .edge_mask_right (edge_mask_right),
    .adv             (adv),
    .item_valid      (item_valid),
    .item            (item)
  );

  msp_span_scan #(
    .COORD_BITS    (COORD_BITS),
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .adv         (adv),
    .row_start_x (row_start_x),
    .result      (set)
  );

  msp_span_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (adv),
    .set        (set),
    .can_load   (can_load),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .head       (head),
    .head_y     (head_y),
    .head_final (m_tlast)
  );

  assign m_tdata = {3'b000, head.width, head_y, head.x};

endmodule

`default_nettype wire

// File: hw/rtl/msp_in_stage.sv
// msp_in_stage: input register for mask bytes; applies the row edge masks on load.
// Depends on msp_pkg.
`default_nettype none

module msp_in_stage import msp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire byte_item_t s_item,
  input  wire logic [7:0] edge_mask_left,
  input  wire logic [7:0] edge_mask_right,
  input  wire logic       adv,
  output logic            item_valid,
  output byte_item_t      item
);

  logic       vld;
  byte_item_t held;
  logic [7:0] masked;
  byte_item_t loaded;

  assign s_tready   = !vld || adv;
  assign item_valid = vld;
  assign item       = held;

  always_comb begin
    masked = s_item.mask_byte;
    if (s_item.row_first) masked = masked & edge_mask_left;
    if (s_item.row_last)  masked = masked & edge_mask_right;
    loaded           = s_item;
    loaded.mask_byte = masked;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_tready) begin
      vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      held <= loaded;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/msp_span_scan.sv
// msp_span_scan: row state registers and the eight-pixel run scan of one byte.
// Depends on msp_pkg.
`default_nettype none

module msp_span_scan import msp_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire byte_item_t         item,
  input  wire logic               adv,
  input  wire logic signed [15:0] row_start_x,
  output span_set_t               result
);

  localparam int WMAX_RAW = MAX_ROW_BYTES * 8;
  localparam logic [WIDTH_W-1:0] SPAN_WMAX = WIDTH_W'(WMAX_RAW > 8191 ? 8191 : WMAX_RAW);

  logic                  in_run, in_run_next;
  logic [COORD_BITS-1:0] run_start, run_start_next;
  logic [COORD_BITS-1:0] pixel_x, pixel_x_next;
  logic [WIDTH_W-1:0]    run_len, run_len_next;

  logic [COORD_BITS-1:0] px0;
  logic [COORD_BITS-1:0] xi;
  logic [SPAN_CNT_W-1:0] n;

  always_comb begin
    px0            = item.row_first ? COORD_BITS'(row_start_x) : pixel_x;
    in_run_next    = item.row_first ? 1'b0 : in_run;
    run_len_next   = item.row_first ? '0 : run_len;
    run_start_next = run_start;
    n              = '0;
    xi             = px0;
    result         = '0;
    result.y       = item.row_y;
    // MSB is the leftmost pixel
    for (int i = 0; i < 8; i++) begin
      xi = px0 + COORD_BITS'(i);
      if (item.mask_byte[7-i]) begin
        if (!in_run_next) begin
          run_start_next = xi;
          in_run_next    = 1'b1;
          run_len_next   = '0;
        end
        if (run_len_next < SPAN_WMAX) run_len_next = run_len_next + 1'b1;
      end else if (in_run_next) begin
        if (n < SPAN_CNT_W'(MAX_SPANS)) begin
          result.spans[n[1:0]].x     = 16'($signed(run_start_next));
          result.spans[n[1:0]].width = run_len_next;
          n = n + 1'b1;
        end
        in_run_next  = 1'b0;
        run_len_next = '0;
      end
    end
    // close a run still open at the row end; dropped if four already went out
    if (item.row_last && in_run_next) begin
      if (n < SPAN_CNT_W'(MAX_SPANS)) begin
        result.spans[n[1:0]].x     = 16'($signed(run_start_next));
        result.spans[n[1:0]].width = run_len_next;
        n = n + 1'b1;
      end
      in_run_next  = 1'b0;
      run_len_next = '0;
    end
    result.cnt   = n;
    pixel_x_next = px0 + COORD_BITS'(8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run    <= 1'b0;
      run_start <= '0;
      pixel_x   <= '0;
      run_len   <= '0;
    end else if (adv) begin
      in_run    <= in_run_next;
      run_start <= run_start_next;
      pixel_x   <= pixel_x_next;
      run_len   <= run_len_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/msp_span_buf.sv
// msp_span_buf: result buffer for one byte's spans, drained one per cycle while m_tready holds.
// Depends on msp_pkg.
`default_nettype none

module msp_span_buf import msp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire span_set_t set,
  output logic           can_load,
  output logic           m_tvalid,
  input  wire logic      m_tready,
  output span_t          head,
  output logic signed [15:0] head_y,
  output logic           head_final
);

  logic [SPAN_CNT_W-1:0] cnt;
  span_t [MAX_SPANS-1:0] ents;
  logic signed [15:0]    y;
  logic                  pop;

  assign pop        = m_tvalid && m_tready;
  assign can_load   = (cnt == '0) || ((cnt == SPAN_CNT_W'(1)) && m_tready);
  assign m_tvalid   = (cnt != '0);
  assign head       = ents[0];
  assign head_y     = y;
  assign head_final = (cnt == SPAN_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= set.cnt;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ents <= set.spans;
      y    <= set.y;
    end else if (pop) begin
      for (int i = 0; i < MAX_SPANS - 1; i++) ents[i] <= ents[i+1];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/msp_checker.sv
// msp_checker: port-level assertions for mask_row_to_spans, bound to the top level.
// Depends on msp_pkg.
`default_nettype none

module msp_checker import msp_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tlast
);

  // a span never has zero width
  a_width_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[44:32] != '0))
    else $error("span with zero width");

  // output is empty the cycle after reset
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("span valid right after reset");

  // input register is empty after reset, so an item can be taken
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready right after reset");

  // a span that is not final is followed by more spans of the same byte
  a_group_continues: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("span group broken off before final");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled span changed");

endmodule

bind mask_row_to_spans msp_checker u_msp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// File: verif/span_check_pkg.sv
// span_check_pkg: span predictor and in-order checker for the mask_row_to_spans bench.
// Depends on msp_pkg for register indexes and field widths.
package span_check_pkg;
  import msp_pkg::*;

  // a run longer than a full row is clipped to this width
  localparam int WIDTH_CAP = (MAX_ROW_BYTES_DEF * 8 > 8191) ? 8191 : MAX_ROW_BYTES_DEF * 8;

  typedef struct {
    logic [15:0]        x;
    logic [15:0]        y;
    logic [WIDTH_W-1:0] width;
    logic               is_last;
  } span_rec_t;

  class span_checker;
    logic [7:0]         mask_left;
    logic [7:0]         mask_right;
    logic [15:0]        start_x;
    bit                 open_run;
    logic [15:0]        open_start;
    logic [15:0]        next_x;
    logic [WIDTH_W-1:0] open_len;
    span_rec_t          pending_spans[$];
    span_rec_t          byte_spans[$];
    int unsigned        mismatches;
    int unsigned        span_count;

    function new();
      mask_left  = EDGE_MASK_RST;
      mask_right = EDGE_MASK_RST;
      start_x    = '0;
      open_run   = 1'b0;
      open_start = '0;
      next_x     = '0;
      open_len   = '0;
      mismatches = 0;
      span_count = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_EDGE_MASK_LEFT) begin
        mask_left = val[7:0];
      end else if (idx == REG_EDGE_MASK_RIGHT) begin
        mask_right = val[7:0];
      end else if (idx == REG_ROW_START_X) begin
        start_x = val[15:0];
      end
    endfunction

    // spans past the fourth of one byte are lost, the run still closes
    function void close_run(logic [15:0] y);
      span_rec_t s;
      if (byte_spans.size() < MAX_SPANS) begin
        s.x       = open_start;
        s.y       = y;
        s.width   = open_len;
        s.is_last = 1'b0;
        byte_spans.push_back(s);
      end
      open_run = 1'b0;
      open_len = '0;
    endfunction

    function void take_byte(logic [7:0] mask_in, logic [15:0] y, logic first, logic last);
      logic [7:0] pix;
      span_rec_t  s;
      pix = mask_in;
      byte_spans.delete();
      if (first) begin
        next_x   = start_x;
        open_run = 1'b0;
        open_len = '0;
        pix      = pix & mask_left;
      end
      if (last) begin
        pix = pix & mask_right;
      end
      for (int k = 7; k >= 0; k--) begin
        if (pix[k]) begin
          if (!open_run) begin
            open_start = next_x;
            open_run   = 1'b1;
            open_len   = '0;
          end
          if (open_len < WIDTH_CAP) begin
            open_len = open_len + 1'b1;
          end
        end else if (open_run) begin
          close_run(y);
        end
        next_x = next_x + 16'd1;
      end
      if (last && open_run) begin
        close_run(y);
      end
      if (byte_spans.size() > 0) begin
        s = byte_spans.pop_back();
        s.is_last = 1'b1;
        byte_spans.push_back(s);
      end
      foreach (byte_spans[i]) begin
        pending_spans.push_back(byte_spans[i]);
      end
    endfunction

    function void check_span(logic [OUT_DATA_W-1:0] data, logic last);
      span_rec_t e;
      span_count++;
      if (pending_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("span %0d unexpected: x=%0d y=%0d w=%0d last=%0b", span_count,
                   $signed(data[15:0]), $signed(data[31:16]), data[44:32], last);
        end
        return;
      end
      e = pending_spans.pop_front();
      if (data[15:0] !== e.x || data[31:16] !== e.y || data[44:32] !== e.width ||
          data[47:45] !== 3'b000 || last !== e.is_last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("span %0d mismatch: expected x=%0d y=%0d w=%0d last=%0b",
                   span_count, $signed(e.x), $signed(e.y), e.width, e.is_last);
          $display("  got x=%0d y=%0d w=%0d last=%0b pad=%0h",
                   $signed(data[15:0]), $signed(data[31:16]), data[44:32], last,
                   data[47:45]);
        end
      end
    endfunction

    function int pending();
      return pending_spans.size();
    endfunction
  endclass

endpackage

// File: verif/tb_mask_row_to_spans.sv
// tb_mask_row_to_spans: drives mask bytes and register writes into mask_row_to_spans
// and checks every span in order. Depends on msp_pkg and span_check_pkg.
module tb_mask_row_to_spans;
  timeunit 1ns;
  timeprecision 1ps;
  import msp_pkg::*;
  import span_check_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_SLACK = 8;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // mask_byte[7:0], row_y[23:8]
  logic                  s_tuser = 1'b0; // row_first
  logic                  s_tlast = 1'b0; // row_last
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // span_x[15:0], span_y[31:16], span_width[44:32]
  logic                  m_tlast;        // span_final

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  span_checker sb = new();

  mask_row_to_spans dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_span(m_tdata, m_tlast);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_mask_row_to_spans: errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] mask_in, input logic [15:0] y,
                           input logic first, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, mask_in};
    s_tuser  <= first;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_byte(mask_in, y, first, last);
  endtask

  // stop sending and let every span come out, with slack for bytes that give none
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_mask();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h55;
      3: return 8'hAA;
      4: return 8'h80 >> $urandom_range(7);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_config();
    logic [7:0]  edge_l;
    logic [7:0]  edge_r;
    logic [15:0] sx;
    case ($urandom_range(5))
      0: edge_l = 8'h00;
      1: edge_l = 8'hFF;
      default: edge_l = 8'($urandom);
    endcase
    case ($urandom_range(5))
      0: edge_r = 8'h00;
      1: edge_r = 8'hFF;
      default: edge_r = 8'($urandom);
    endcase
    case ($urandom_range(4))
      0: sx = 16'h8000;
      1: sx = 16'h7FFF;
      2: sx = 16'h7FF8;
      default: sx = 16'($urandom);
    endcase
    write_reg(REG_EDGE_MASK_LEFT, {8'($urandom), edge_l});
    write_reg(REG_EDGE_MASK_RIGHT, {8'($urandom), edge_r});
    write_reg(REG_ROW_START_X, sx);
  endtask

  // mostly whole rows; the rest are loose bytes with random row markers
  task automatic run_random(input int target, input int send_pct, input int recv_pct);
    int          sent;
    int          nbytes;
    logic [15:0] y;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 85) begin
        nbytes = $urandom_range(1, 6);
        y = 16'($urandom);
        for (int i = 0; i < nbytes; i++) begin
          if ($urandom_range(9) == 0) y = 16'($urandom);
          send_byte(pick_mask(), y, i == 0, i == nbytes - 1);
        end
        sent += nbytes;
        if ($urandom_range(9) == 0) drain();
      end else begin
        send_byte(pick_mask(), 16'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_byte(8'hC3, 16'h0005, 1'b0, 1'b0);  // no row start: x counts from 0
    send_byte(8'h80, 16'h8000, 1'b0, 1'b1);  // row y changes inside the row
    send_byte(8'hFF, 16'h7FFF, 1'b1, 1'b1);
    send_byte(8'h00, 16'h0000, 1'b1, 1'b1);
    send_byte(8'h01, 16'h1234, 1'b1, 1'b0);  // run left open
    send_byte(8'hFF, 16'h1235, 1'b1, 1'b1);  // new row discards it
    send_byte(8'h01, 16'h0001, 1'b1, 1'b0);
    send_byte(8'h55, 16'h0002, 1'b0, 1'b1);  // five closes, the row-end one is lost
    send_byte(8'h0F, 16'hFFFF, 1'b1, 1'b0);
    send_byte(8'hFF, 16'hFFFF, 1'b0, 1'b0);
    send_byte(8'hF0, 16'hFFFF, 1'b0, 1'b1);
    drain();

    write_reg(REG_EDGE_MASK_LEFT, 16'hA57E);
    write_reg(REG_EDGE_MASK_RIGHT, 16'h5AE7);
    write_reg(REG_ROW_START_X, 16'h7FFC);    // row crosses the x wrap
    write_reg(CFG_ADDR_SPARE, 16'hFFFF);     // unmapped index, no effect
    send_byte(8'hFF, 16'h0010, 1'b1, 1'b1);
    send_byte(8'hFF, 16'h0011, 1'b1, 1'b0);
    send_byte(8'hFF, 16'h0011, 1'b0, 1'b1);
    drain();

    write_reg(REG_EDGE_MASK_LEFT, 16'h0000);
    write_reg(REG_EDGE_MASK_RIGHT, 16'h0000);
    write_reg(REG_ROW_START_X, 16'h8000);
    send_byte(8'hFF, 16'h0020, 1'b1, 1'b0);
    send_byte(8'hFF, 16'h0020, 1'b0, 1'b0);
    send_byte(8'hFF, 16'h0020, 1'b0, 1'b0);
    send_byte(8'hFF, 16'h0020, 1'b0, 1'b1);
    drain();

    random_config();
    run_random(33, 0, 0);
    random_config();
    run_random(33, 57, 0);
    random_config();
    run_random(33, 0, 57);
    random_config();
    run_random(33, 19, 19);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_mask_row_to_spans: clean");
    end else begin
      $display("tb_mask_row_to_spans: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/msp_pkg.sv
hw/rtl/msp_in_stage.sv
hw/rtl/msp_span_scan.sv
hw/rtl/msp_span_buf.sv
hw/rtl/mask_row_to_spans.sv
hw/rtl/msp_checker.sv
verif/span_check_pkg.sv
verif/tb_mask_row_to_spans.sv
